// File: src/pod_pkg.sv
// ---------------------------------------------------------------------------
// pod_pkg
// Shared types, constants and fixed-point helpers for the pendulum integrator.
// ---------------------------------------------------------------------------
`default_nettype none

package pod_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_METHOD      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ANGLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_RATE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_LIMIT  = 3'd5;
   localparam int CSR_DATA_W = 32;

   // Integration methods (code 3 runs as RK4)
   localparam logic [1:0] METHOD_EULER = 2'd0;
   localparam logic [1:0] METHOD_HEUN  = 2'd1;
   localparam logic [1:0] METHOD_RK4   = 2'd2;

   // Q2.30 angle constants
   localparam logic signed [35:0] Q30_PI       = 36'sd3373259426;
   localparam logic signed [35:0] Q30_HALF_PI  = 36'sd1686629713;
   localparam logic signed [35:0] Q30_TWO_PI   = 36'sd6746518852;
   localparam logic signed [35:0] CORDIC_SCALE = 36'sd652032874;

   localparam logic [19:0] STEP_MAX = 20'hFFFFF;
   localparam int CNT_W = 6;

   typedef struct packed {
      logic [1:0]          method;
      logic [24:0]         step_size;
      logic [30:0]         gain;
      logic signed [31:0]  start_angle;
      logic signed [31:0]  start_rate;
      logic [19:0]         step_limit;
   } cfg_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_RESTART, DP_START, DP_RED_LOAD, DP_RED_STEP, DP_FOLD1, DP_FOLD2,
      DP_CORDIC, DP_GMUL, DP_SLOPE, DP_ACC_SET, DP_ACC_ADD1, DP_ACC_ADD2,
      DP_MUL_K, DP_MOVE, DP_MUL_A, DP_NEW, DP_DIV_LOAD, DP_DIV_STEP, DP_NEW_DIV
   } dp_op_type;

   typedef struct packed {
      dp_op_type          op;
      logic               sel_r;   // 0 angle lane, 1 rate lane
      logic               half;    // round by one more fraction bit
      logic [CNT_W-1:0]   idx;     // iteration / shift index
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RED_LOAD, ST_RED, ST_FOLD1, ST_FOLD2, ST_CORDIC, ST_GMUL,
      ST_SLOPE, ST_ACC, ST_MUL_K, ST_MOVE, ST_MUL_A, ST_NEW, ST_DIV_LOAD,
      ST_DIV, ST_NEW_DIV
   } state_type;

   // Reset values of the registers, for a given fraction width
   function automatic logic [24:0] reset_step(input int frac);
      longint one;
      one = longint'(1) <<< frac;
      return 25'((one + 50) / 100);
   endfunction

   function automatic logic [30:0] reset_gain(input int frac);
      longint one;
      one = longint'(1) <<< frac;
      return 31'((981 * one + 20) / 40);
   endfunction

   function automatic logic signed [31:0] reset_angle(input int frac);
      longint hp;
      hp = longint'(Q30_HALF_PI);
      return 32'((hp + (longint'(1) <<< (29 - frac))) >>> (30 - frac));
   endfunction

   // Round to nearest, ties away from zero, then shift right by n
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] p,
                                                      input int n);
      logic signed [63:0] half;
      half = 64'sd1 <<< (n - 1);
      if (p >= 0) begin
         return (p + half) >>> n;
      end
      return -((-p + half) >>> n);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Arctangent of 2^-i in Q2.30
   function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
      logic signed [35:0] v;
      unique case (i)
         5'd0:  v = 36'sd843314856;
         5'd1:  v = 36'sd497837829;
         5'd2:  v = 36'sd263043836;
         5'd3:  v = 36'sd133525158;
         5'd4:  v = 36'sd67021686;
         5'd5:  v = 36'sd33543515;
         5'd6:  v = 36'sd16775850;
         5'd7:  v = 36'sd8388437;
         5'd8:  v = 36'sd4194282;
         5'd9:  v = 36'sd2097149;
         5'd10: v = 36'sd1048575;
         5'd11: v = 36'sd524287;
         5'd12: v = 36'sd262143;
         5'd13: v = 36'sd131071;
         5'd14: v = 36'sd65535;
         5'd15: v = 36'sd32767;
         5'd16: v = 36'sd16383;
         5'd17: v = 36'sd8191;
         5'd18: v = 36'sd4095;
         5'd19: v = 36'sd2047;
         5'd20: v = 36'sd1023;
         5'd21: v = 36'sd511;
         5'd22: v = 36'sd255;
         5'd23: v = 36'sd127;
         5'd24: v = 36'sd63;
         5'd25: v = 36'sd31;
         5'd26: v = 36'sd15;
         5'd27: v = 36'sd7;
         5'd28: v = 36'sd3;
         5'd29: v = 36'sd1;
         default: v = 36'sd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: src/pod_if.sv
// ---------------------------------------------------------------------------
// pod_req_if / pod_rsp_if
// Valid/ready channels for tick words and sample words.
// ---------------------------------------------------------------------------
`default_nettype none

interface pod_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface pod_rsp_if;
   logic               valid;
   logic               ready;
   logic [19:0]        step_index;
   logic signed [31:0] angle;
   logic signed [31:0] rate;
   modport source (output valid, output step_index, output angle, output rate,
                   input ready);
   modport sink (input valid, input step_index, input angle, input rate,
                 output ready);
endinterface

`default_nettype wire

// File: src/pod_datapath.sv
// ---------------------------------------------------------------------------
// pod_datapath
// State, slope and step registers with one shared multiplier, the angle
// reduction, the CORDIC sine and the divide-by-six unit.
// ---------------------------------------------------------------------------
`default_nettype none

module pod_datapath #(
   parameter int FRAC_BITS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pod_pkg::cfg_type   cfg,
   input  wire pod_pkg::cmd_type   cmd,
   output logic signed [31:0]      angle_o,
   output logic signed [31:0]      rate_o
);

   localparam int RED_SHIFT  = 30 - FRAC_BITS;
   localparam int DIV_DIGITS = (71 - FRAC_BITS) / 8;
   localparam int DIV_W      = 8 * DIV_DIGITS;
   localparam logic [35:0] Q30_TWO_PI_U = pod_pkg::Q30_TWO_PI;
   // ceil(2^18 / 6): exact quotient for any byte digit with remainder below six
   localparam logic [15:0] DIV6_RECIP = 16'd43691;

   logic signed [31:0] q_ff, q_in, r_ff, r_in;
   logic signed [31:0] qs_ff, qs_in, rs_ff, rs_in;
   logic signed [31:0] kq_ff, kq_in, kr_ff, kr_in;
   logic signed [34:0] accq_ff, accq_in, accr_ff, accr_in;
   logic signed [31:0] outq_ff, outq_in, outr_ff, outr_in;
   logic [63:0]        red_ff, red_in;
   logic               neg_ff, neg_in;
   logic signed [35:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [DIV_W-1:0]   num_ff, num_in;
   logic [2:0]         rem_ff, rem_in;
   logic               dneg_ff, dneg_in;

   logic [31:0]        mul_a;
   logic signed [35:0] mul_b;
   logic signed [68:0] mul_full;
   logic signed [63:0] base64, move_sum, div_q, a64, ra64;
   logic [63:0]        a_mag, two_pi_sh, p_mag;
   logic signed [35:0] ra, xs, ys;
   logic [10:0]        dtry, drem;
   logic [25:0]        dprod;
   logic [7:0]         dq8;
   logic signed [31:0] base32;

   // Shared multiplier operands
   always_comb begin
      unique case (cmd.op)
         pod_pkg::DP_GMUL: begin
            mul_a = {1'b0, cfg.gain};
            mul_b = y_ff;
         end
         pod_pkg::DP_MUL_A: begin
            mul_a = {7'd0, cfg.step_size};
            mul_b = cmd.sel_r ? 36'(accr_ff) : 36'(accq_ff);
         end
         default: begin
            mul_a = {7'd0, cfg.step_size};
            mul_b = cmd.sel_r ? 36'(kr_ff) : 36'(kq_ff);
         end
      endcase
   end
   assign mul_full = $signed({1'b0, mul_a}) * mul_b;

   // Lane select and shared add / round / saturate paths
   assign base32    = cmd.sel_r ? r_ff : q_ff;
   assign base64    = {{32{base32[31]}}, base32};
   assign move_sum  = base64 + pod_pkg::round_shift(prod_ff,
                         cmd.half ? FRAC_BITS + 1 : FRAC_BITS);
   assign div_q     = dneg_ff ? -$signed(64'(num_ff)) : $signed(64'(num_ff));
   assign a64       = {{32{qs_ff[31]}}, qs_ff} <<< RED_SHIFT;
   assign a_mag     = a64[63] ? 64'(-a64) : 64'(a64);
   assign two_pi_sh = {28'd0, Q30_TWO_PI_U} << cmd.idx;
   assign ra64      = neg_ff ? -$signed(red_ff) : $signed(red_ff);
   assign ra        = ra64[35:0];
   assign xs        = x_ff >>> cmd.idx;
   assign ys        = y_ff >>> cmd.idx;
   assign p_mag     = (prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff))
                      + (64'd3 << FRAC_BITS);

   // One byte digit of the divide by six: reciprocal multiply, then remainder
   assign dtry      = {rem_ff, num_ff[DIV_W-1 -: 8]};
   assign dprod     = 26'(dtry) * 26'(DIV6_RECIP);
   assign dq8       = dprod[25:18];
   assign drem      = dtry - 11'(dq8) * 11'd6;

   // Next-state logic
   always_comb begin
      q_in = q_ff;  r_in = r_ff;  qs_in = qs_ff;  rs_in = rs_ff;
      kq_in = kq_ff;  kr_in = kr_ff;  accq_in = accq_ff;  accr_in = accr_ff;
      outq_in = outq_ff;  outr_in = outr_ff;  red_in = red_ff;  neg_in = neg_ff;
      x_in = x_ff;  y_in = y_ff;  z_in = z_ff;  prod_in = prod_ff;
      num_in = num_ff;  rem_in = rem_ff;  dneg_in = dneg_ff;
      unique case (cmd.op)
         pod_pkg::DP_RESTART: begin
            q_in = cfg.start_angle;
            r_in = cfg.start_rate;
         end
         pod_pkg::DP_START: begin
            qs_in = q_ff;  rs_in = r_ff;
            outq_in = q_ff;  outr_in = r_ff;
         end
         pod_pkg::DP_RED_LOAD: begin
            red_in = a_mag;
            neg_in = a64[63];
         end
         pod_pkg::DP_RED_STEP: begin
            if (red_ff >= two_pi_sh) begin
               red_in = red_ff - two_pi_sh;
            end
         end
         // wrap into [-pi, pi]
         pod_pkg::DP_FOLD1: begin
            priority if (ra > pod_pkg::Q30_PI) begin
               z_in = ra - pod_pkg::Q30_TWO_PI;
            end else if (ra < -pod_pkg::Q30_PI) begin
               z_in = ra + pod_pkg::Q30_TWO_PI;
            end else begin
               z_in = ra;
            end
         end
         // fold into [-pi/2, pi/2], seed the rotation
         pod_pkg::DP_FOLD2: begin
            priority if (z_ff > pod_pkg::Q30_HALF_PI) begin
               z_in = pod_pkg::Q30_PI - z_ff;
            end else if (z_ff < -pod_pkg::Q30_HALF_PI) begin
               z_in = -pod_pkg::Q30_PI - z_ff;
            end else begin
               z_in = z_ff;
            end
            x_in = pod_pkg::CORDIC_SCALE;
            y_in = '0;
         end
         pod_pkg::DP_CORDIC: begin
            if (z_ff >= 0) begin
               x_in = x_ff - ys;  y_in = y_ff + xs;
               z_in = z_ff - pod_pkg::atan_q30(cmd.idx[4:0]);
            end else begin
               x_in = x_ff + ys;  y_in = y_ff - xs;
               z_in = z_ff + pod_pkg::atan_q30(cmd.idx[4:0]);
            end
         end
         pod_pkg::DP_GMUL, pod_pkg::DP_MUL_K, pod_pkg::DP_MUL_A: begin
            prod_in = mul_full[63:0];
         end
         pod_pkg::DP_SLOPE: begin
            kq_in = rs_ff;
            kr_in = pod_pkg::sat32(-pod_pkg::round_shift(prod_ff, 30));
         end
         pod_pkg::DP_ACC_SET: begin
            accq_in = 35'(kq_ff);  accr_in = 35'(kr_ff);
         end
         pod_pkg::DP_ACC_ADD1: begin
            accq_in = accq_ff + 35'(kq_ff);  accr_in = accr_ff + 35'(kr_ff);
         end
         pod_pkg::DP_ACC_ADD2: begin
            accq_in = accq_ff + (35'(kq_ff) <<< 1);
            accr_in = accr_ff + (35'(kr_ff) <<< 1);
         end
         pod_pkg::DP_MOVE: begin
            if (cmd.sel_r) begin
               rs_in = pod_pkg::sat32(move_sum);
            end else begin
               qs_in = pod_pkg::sat32(move_sum);
            end
         end
         pod_pkg::DP_NEW: begin
            if (cmd.sel_r) begin
               r_in = pod_pkg::sat32(move_sum);
            end else begin
               q_in = pod_pkg::sat32(move_sum);
            end
         end
         // (|p| + 3*2^F) >> F, then divide by six a byte per cycle
         pod_pkg::DP_DIV_LOAD: begin
            num_in  = DIV_W'(p_mag[63:FRAC_BITS]);
            rem_in  = '0;
            dneg_in = prod_ff[63];
         end
         pod_pkg::DP_DIV_STEP: begin
            rem_in = drem[2:0];
            num_in = {num_ff[DIV_W-9:0], dq8};
         end
         pod_pkg::DP_NEW_DIV: begin
            if (cmd.sel_r) begin
               r_in = pod_pkg::sat32(base64 + div_q);
            end else begin
               q_in = pod_pkg::sat32(base64 + div_q);
            end
         end
         default: begin
            q_in = q_ff;
         end
      endcase
   end

   // Pendulum state
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= pod_pkg::reset_angle(FRAC_BITS);
         r_ff <= '0;
      end else begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      qs_ff <= qs_in;  rs_ff <= rs_in;  kq_ff <= kq_in;  kr_ff <= kr_in;
      accq_ff <= accq_in;  accr_ff <= accr_in;  outq_ff <= outq_in;
      outr_ff <= outr_in;  red_ff <= red_in;  neg_ff <= neg_in;
      x_ff <= x_in;  y_ff <= y_in;  z_ff <= z_in;  prod_ff <= prod_in;
      num_ff <= num_in;  rem_ff <= rem_in;  dneg_ff <= dneg_in;
   end

   assign angle_o = outq_ff;
   assign rate_o  = outr_ff;

   // after each divide step the division remainder stays below six
   assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'd5 || $past(cmd.op) != pod_pkg::DP_DIV_STEP)
      else $error("divider remainder out of range");

   // after a fold the angle lies within a quarter turn
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == pod_pkg::DP_FOLD2 |=>
         z_ff <= pod_pkg::Q30_HALF_PI && z_ff >= -pod_pkg::Q30_HALF_PI)
      else $error("sine argument not folded");

   // reduction leaves less than a full turn
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == pod_pkg::DP_FOLD1 |-> red_ff < 64'(Q30_TWO_PI_U))
      else $error("angle reduction incomplete");

endmodule

`default_nettype wire

// File: src/pod_controller.sv
// ---------------------------------------------------------------------------
// pod_controller
// Sequencer for one integration step: slope evaluations, stage moves and the
// final update; also owns the step count and the sample word handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module pod_controller #(
   parameter int FRAC_BITS       = 24,
   parameter int SINE_ITERATIONS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pod_pkg::cfg_type   cfg,
   input  wire logic               req_valid,
   input  wire logic               req_restart,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [19:0]             rsp_index,
   output pod_pkg::cmd_type        cmd
);

   localparam int RED_LAST  = 29 - FRAC_BITS;
   localparam int CORD_LAST = SINE_ITERATIONS - 1;
   localparam int DIV_LAST  = (71 - FRAC_BITS) / 8 - 1;

   pod_pkg::state_type          state_ff, state_in;
   logic [pod_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]                  ev_ff, ev_in;
   logic                        sel_ff, sel_in;
   logic [19:0]                 steps_ff, steps_in;
   logic                        fin_ff, fin_in;
   logic                        rspv_ff, rspv_in;
   logic [19:0]                 idx_ff, idx_in;
   logic                        is_euler, is_heun, is_rk4, last_eval, tick;

   assign is_euler  = cfg.method == pod_pkg::METHOD_EULER;
   assign is_heun   = cfg.method == pod_pkg::METHOD_HEUN;
   assign is_rk4    = cfg.method[1];
   assign last_eval = is_euler || (is_heun && ev_ff == 2'd1) || (is_rk4 && ev_ff == 2'd3);
   assign req_ready = state_ff == pod_pkg::ST_IDLE && (!rspv_ff || rsp_ready);
   assign tick      = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;  cnt_in = cnt_ff;  ev_in = ev_ff;  sel_in = sel_ff;
      steps_in = steps_ff;  fin_in = fin_ff;  idx_in = idx_ff;
      rspv_in  = rspv_ff && !rsp_ready;
      cmd.op = pod_pkg::DP_NOP;  cmd.sel_r = sel_ff;  cmd.half = 1'b0;
      cmd.idx = cnt_ff;
      unique case (state_ff)
         pod_pkg::ST_IDLE: begin
            if (tick) begin
               if (req_restart) begin
                  cmd.op = pod_pkg::DP_RESTART;
                  steps_in = '0;
                  fin_in = 1'b0;
               end else if (!fin_ff && steps_ff <= cfg.step_limit) begin
                  cmd.op = pod_pkg::DP_START;
                  rspv_in = 1'b1;
                  idx_in = steps_ff;
                  if (steps_ff == pod_pkg::STEP_MAX) begin
                     fin_in = 1'b1;
                  end else begin
                     steps_in = steps_ff + 20'd1;
                  end
                  ev_in = '0;
                  state_in = pod_pkg::ST_RED_LOAD;
               end
            end
         end
         pod_pkg::ST_RED_LOAD: begin
            cmd.op = pod_pkg::DP_RED_LOAD;
            cnt_in = pod_pkg::CNT_W'(RED_LAST);
            state_in = pod_pkg::ST_RED;
         end
         pod_pkg::ST_RED: begin
            cmd.op = pod_pkg::DP_RED_STEP;
            if (cnt_ff == '0) begin
               state_in = pod_pkg::ST_FOLD1;
            end else begin
               cnt_in = cnt_ff - pod_pkg::CNT_W'(1);
            end
         end
         pod_pkg::ST_FOLD1: begin
            cmd.op = pod_pkg::DP_FOLD1;
            state_in = pod_pkg::ST_FOLD2;
         end
         pod_pkg::ST_FOLD2: begin
            cmd.op = pod_pkg::DP_FOLD2;
            cnt_in = '0;
            state_in = pod_pkg::ST_CORDIC;
         end
         pod_pkg::ST_CORDIC: begin
            cmd.op = pod_pkg::DP_CORDIC;
            if (cnt_ff == pod_pkg::CNT_W'(CORD_LAST)) begin
               state_in = pod_pkg::ST_GMUL;
            end else begin
               cnt_in = cnt_ff + pod_pkg::CNT_W'(1);
            end
         end
         pod_pkg::ST_GMUL: begin
            cmd.op = pod_pkg::DP_GMUL;
            state_in = pod_pkg::ST_SLOPE;
         end
         pod_pkg::ST_SLOPE: begin
            cmd.op = pod_pkg::DP_SLOPE;
            state_in = pod_pkg::ST_ACC;
         end
         // weight the slope into the sum: 1, 2, 2, 1 for RK4
         pod_pkg::ST_ACC: begin
            priority if (ev_ff == 2'd0) begin
               cmd.op = pod_pkg::DP_ACC_SET;
            end else if (is_rk4 && ev_ff != 2'd3) begin
               cmd.op = pod_pkg::DP_ACC_ADD2;
            end else begin
               cmd.op = pod_pkg::DP_ACC_ADD1;
            end
            sel_in = 1'b0;
            state_in = last_eval ? pod_pkg::ST_MUL_A : pod_pkg::ST_MUL_K;
         end
         pod_pkg::ST_MUL_K: begin
            cmd.op = pod_pkg::DP_MUL_K;
            state_in = pod_pkg::ST_MOVE;
         end
         pod_pkg::ST_MOVE: begin
            cmd.op = pod_pkg::DP_MOVE;
            cmd.half = is_rk4 && ev_ff != 2'd2;
            if (!sel_ff) begin
               sel_in = 1'b1;
               state_in = pod_pkg::ST_MUL_K;
            end else begin
               ev_in = ev_ff + 2'd1;
               state_in = pod_pkg::ST_RED_LOAD;
            end
         end
         pod_pkg::ST_MUL_A: begin
            cmd.op = pod_pkg::DP_MUL_A;
            state_in = is_rk4 ? pod_pkg::ST_DIV_LOAD : pod_pkg::ST_NEW;
         end
         pod_pkg::ST_DIV_LOAD: begin
            cmd.op = pod_pkg::DP_DIV_LOAD;
            cnt_in = pod_pkg::CNT_W'(DIV_LAST);
            state_in = pod_pkg::ST_DIV;
         end
         pod_pkg::ST_DIV: begin
            cmd.op = pod_pkg::DP_DIV_STEP;
            if (cnt_ff == '0) begin
               state_in = pod_pkg::ST_NEW_DIV;
            end else begin
               cnt_in = cnt_ff - pod_pkg::CNT_W'(1);
            end
         end
         pod_pkg::ST_NEW, pod_pkg::ST_NEW_DIV: begin
            cmd.op = (state_ff == pod_pkg::ST_NEW) ? pod_pkg::DP_NEW : pod_pkg::DP_NEW_DIV;
            cmd.half = is_heun;
            if (!sel_ff) begin
               sel_in = 1'b1;
               state_in = pod_pkg::ST_MUL_A;
            end else begin
               state_in = pod_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pod_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pod_pkg::ST_IDLE;
         cnt_ff   <= '0;
         ev_ff    <= '0;
         sel_ff   <= 1'b0;
         steps_ff <= '0;
         fin_ff   <= 1'b0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ev_ff    <= ev_in;
         sel_ff   <= sel_in;
         steps_ff <= steps_in;
         fin_ff   <= fin_in;
         rspv_ff  <= rspv_in;
      end
   end

   // Sample index
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   assign rsp_valid = rspv_ff;
   assign rsp_index = idx_ff;

   // a plain tick up to the limit, below STEP_MAX, adds one to the step count
   assert property (@(posedge clock) disable iff (reset)
      tick && !req_restart && !fin_ff && steps_ff <= cfg.step_limit
         && steps_ff != pod_pkg::STEP_MAX |=> steps_ff == $past(steps_ff) + 20'd1)
      else $error("step count did not advance");

   // a new sample is only emitted once the integration has returned to idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rspv_ff) |-> $past(state_ff) == pod_pkg::ST_IDLE)
      else $error("sample emitted mid-step");

   // rotation index never runs past the iteration count
   assert property (@(posedge clock) disable iff (reset)
      state_ff == pod_pkg::ST_CORDIC |-> cnt_ff <= pod_pkg::CNT_W'(CORD_LAST))
      else $error("rotation index overrun");

endmodule

`default_nettype wire

// File: src/pendulum_ode_integrator.sv
// A sample word is valid in the cycle after its tick word is accepted.
// One step per tick; the next tick waits for the step and the last sample word.
// Each slope evaluation reduces, folds and rotates the angle, then applies the gain;
// Euler uses one, Heun two, RK4 four plus a divide of D = (71 - FRAC_BITS)/8 bytes.
// Reset: synchronous; loads default registers, angle pi/2, rate and count zero.
// ---------------------------------------------------------------------------
// pendulum_ode_integrator
// Fixed-point pendulum simulator: one Euler, Heun or RK4 step per non-restart tick word.
// ---------------------------------------------------------------------------
`default_nettype none

module pendulum_ode_integrator #(
   parameter int FRAC_BITS       = 24,
   parameter int SINE_ITERATIONS = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   pod_req_if.sink                                  req_bus,
   pod_rsp_if.source                                rsp_bus,
   input  wire logic                                csr_we,
   input  wire logic [pod_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pod_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   pod_pkg::cfg_type cfg_ff, cfg_in;
   pod_pkg::cmd_type cmd;
   logic             req_ready;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pod_pkg::CSR_METHOD:      cfg_in.method      = csr_wdata[1:0];
            pod_pkg::CSR_STEP_SIZE:   cfg_in.step_size   = csr_wdata[24:0];
            pod_pkg::CSR_GAIN:        cfg_in.gain        = csr_wdata[30:0];
            pod_pkg::CSR_START_ANGLE: cfg_in.start_angle = csr_wdata;
            pod_pkg::CSR_START_RATE:  cfg_in.start_rate  = csr_wdata;
            pod_pkg::CSR_STEP_LIMIT:  cfg_in.step_limit  = csr_wdata[19:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.method      <= pod_pkg::METHOD_EULER;
         cfg_ff.step_size   <= pod_pkg::reset_step(FRAC_BITS);
         cfg_ff.gain        <= pod_pkg::reset_gain(FRAC_BITS);
         cfg_ff.start_angle <= pod_pkg::reset_angle(FRAC_BITS);
         cfg_ff.start_rate  <= '0;
         cfg_ff.step_limit  <= 20'd2000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pod_controller #(
      .FRAC_BITS       (FRAC_BITS),
      .SINE_ITERATIONS (SINE_ITERATIONS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_bus.valid),
      .req_restart (req_bus.restart),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_index   (rsp_bus.step_index),
      .cmd         (cmd)
   );

   pod_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .cmd     (cmd),
      .angle_o (rsp_bus.angle),
      .rate_o  (rsp_bus.rate)
   );

   assign req_bus.ready = req_ready;

endmodule

`default_nettype wire
